// ----- hw/rtl/sust_pkg.sv -----
// shared constants, codes and types of the sorted unique set table
package sust_pkg;

  localparam int CAPACITY = 32;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int VW       = 32;
  localparam int OPW      = 2;
  localparam int STW      = 4;
  localparam int ECW      = 6;
  localparam int IN_TW    = 40;
  localparam int OUT_TW   = 48;

  localparam logic [OPW-1:0] OP_INSERT = 2'd0;
  localparam logic [OPW-1:0] OP_DELETE = 2'd1;
  localparam logic [OPW-1:0] OP_SEARCH = 2'd2;
  localparam logic [OPW-1:0] OP_LIST   = 2'd3;

  localparam logic [STW-1:0] ST_INSERTED  = 4'd0;
  localparam logic [STW-1:0] ST_DUPLICATE = 4'd1;
  localparam logic [STW-1:0] ST_FULL      = 4'd2;
  localparam logic [STW-1:0] ST_DELETED   = 4'd3;
  localparam logic [STW-1:0] ST_DEL_MISS  = 4'd4;
  localparam logic [STW-1:0] ST_FOUND     = 4'd5;
  localparam logic [STW-1:0] ST_NOT_FOUND = 4'd6;
  localparam logic [STW-1:0] ST_ENTRY     = 4'd7;
  localparam logic [STW-1:0] ST_EMPTY     = 4'd8;

  // outcome of comparing the request value against one table entry
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;

endpackage

// ----- hw/rtl/sust_cmp.sv -----
// signed equal / less-than compare unit used by the lookup walk of the table
module sust_cmp (
  input  logic [sust_pkg::VW-1:0] key,
  input  logic [sust_pkg::VW-1:0] entry,
  output sust_pkg::cmp_t          res
);
  import sust_pkg::*;

  assign res.eq = (key == entry);
  assign res.lt = ($signed(key) < $signed(entry));

endmodule

// ----- hw/rtl/sorted_unique_set_table_unit.sv -----
// sorted unique set table: insert, delete, search and list over a bounded sorted table
//
//  channel  dir  signals                       content
//  s_axis   in   tvalid tready tdata[39:0]     operation, value
//  m_axis   out  tvalid tready tdata[47:0]     status, entry_value, entry_count
//                tlast                          last result of the request
//
// search walks the table from entry 0 to the position the walk stops at; an insert or
// delete that goes ahead then moves each entry from that position to the end one place;
// list reads every entry in order. The one-read one-write table memory visits one entry
// per cycle, compared by the single compare unit, unless a stalled result holds a list.
// rst clears the fill count, the sequencer and the output valid; table words are not cleared.
// a stalled result register holds the sequencer wherever it is about to emit.
module sorted_unique_set_table_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [sust_pkg::IN_TW-1:0]   s_axis_tdata,   // operation[1:0], value[33:2]
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [sust_pkg::OUT_TW-1:0]  m_axis_tdata,   // status[3:0], entry_value[35:4],
                                                       // entry_count[41:36]
  output logic                         m_axis_tlast
);
  import sust_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_SHUP = 3'd2;
  localparam logic [2:0] S_SHDN = 3'd3;
  localparam logic [2:0] S_LIST = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]     state, state_next;
  logic [OPW-1:0] op, op_next;
  logic [VW-1:0]  val, val_next;
  logic [CW-1:0]  idx, idx_next;
  logic [CW-1:0]  pos, pos_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic [STW-1:0] status, status_next;

  logic           out_valid;
  logic [STW-1:0] out_status;
  logic [VW-1:0]  out_value;
  logic [ECW-1:0] out_count;
  logic           out_last;

  logic           load;
  logic [STW-1:0] ld_status;
  logic [VW-1:0]  ld_value;
  logic           ld_last;
  logic           out_free;

  logic [VW-1:0]  mem [CAPACITY];
  logic [VW-1:0]  rd_data;
  logic [AW-1:0]  rd_addr;
  logic           we;
  logic [AW-1:0]  waddr;
  logic [VW-1:0]  wdata;

  logic [CW-1:0]  idx_inc, idx_add2, idx_dec, idx_sub2, cnt_dec;
  logic           at_end, hit, stop;
  cmp_t           cmp;

  sust_cmp u_cmp (
    .key   (val),
    .entry (rd_data),
    .res   (cmp)
  );

  assign idx_inc  = idx + CW'(1);
  assign idx_add2 = idx + CW'(2);
  assign idx_dec  = idx - CW'(1);
  assign idx_sub2 = idx - CW'(2);
  assign cnt_dec  = cnt - CW'(1);
  assign at_end   = (idx == cnt);
  assign hit      = !at_end && cmp.eq;
  assign stop     = at_end || cmp.eq || cmp.lt;
  assign out_free = !out_valid || m_axis_tready;

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    op_next     = op;
    val_next    = val;
    idx_next    = idx;
    pos_next    = pos;
    cnt_next    = cnt;
    status_next = status;
    load        = 1'b0;
    ld_status   = status;
    ld_value    = val;
    ld_last     = 1'b1;
    rd_addr     = idx[AW-1:0];
    we          = 1'b0;
    waddr       = idx[AW-1:0];
    wdata       = rd_data;
    case (state)
      S_IDLE: begin
        rd_addr = '0;
        if (s_axis_tvalid) begin
          op_next  = s_axis_tdata[OPW-1:0];
          val_next = s_axis_tdata[OPW +: VW];
          idx_next = '0;
          if (s_axis_tdata[OPW-1:0] == OP_LIST) begin
            if (cnt == '0) begin
              status_next = ST_EMPTY;
              state_next  = S_EMIT;
            end else begin
              state_next = S_LIST;
            end
          end else begin
            state_next = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        // read of the next entry is issued while this one is compared
        rd_addr = idx_inc[AW-1:0];
        if (stop) begin
          pos_next   = idx;
          state_next = S_EMIT;
          case (op)
            OP_SEARCH: status_next = hit ? ST_FOUND : ST_NOT_FOUND;
            OP_INSERT: begin
              if (hit) begin
                status_next = ST_DUPLICATE;
              end else if (cnt == CW'(CAPACITY)) begin
                status_next = ST_FULL;
              end else begin
                idx_next   = cnt;
                rd_addr    = cnt_dec[AW-1:0];
                state_next = S_SHUP;
              end
            end
            OP_DELETE: begin
              if (hit) begin
                idx_next   = idx;
                state_next = S_SHDN;
              end else begin
                status_next = ST_DEL_MISS;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end else begin
          idx_next = idx_inc;
        end
      end
      S_SHUP: begin
        we = 1'b1;
        if (idx == pos) begin
          waddr       = pos[AW-1:0];
          wdata       = val;
          cnt_next    = cnt + CW'(1);
          status_next = ST_INSERTED;
          state_next  = S_EMIT;
        end else begin
          idx_next = idx_dec;
          rd_addr  = idx_sub2[AW-1:0];
        end
      end
      S_SHDN: begin
        if (idx_inc < cnt) begin
          we       = 1'b1;
          idx_next = idx_inc;
          rd_addr  = idx_add2[AW-1:0];
        end else begin
          cnt_next    = cnt_dec;
          status_next = ST_DELETED;
          state_next  = S_EMIT;
        end
      end
      S_LIST: begin
        if (out_free) begin
          load      = 1'b1;
          ld_status = ST_ENTRY;
          ld_value  = rd_data;
          ld_last   = (idx_inc == cnt);
          idx_next  = idx_inc;
          rd_addr   = idx_inc[AW-1:0];
          if (idx_inc == cnt) begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    val    <= val_next;
    idx    <= idx_next;
    pos    <= pos_next;
    status <= status_next;
    if (load) begin
      out_status <= ld_status;
      out_value  <= ld_value;
      out_count  <= ECW'(cnt);
      out_last   <= ld_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {{(OUT_TW - STW - VW - ECW){1'b0}}, out_count, out_value, out_status};

  // fill count never passes the table size
  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // one request moves the fill count by at most one
  assert property (@(posedge clk) disable iff (rst)
    cnt == $past(cnt) || cnt == $past(cnt) + CW'(1) || cnt + CW'(1) == $past(cnt))
    else $error("fill count jumped");

  // only listed entries may be followed by more results of the same request
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_status != ST_ENTRY |-> m_axis_tlast)
    else $error("status result without tlast");

  // an accepted request always starts the sequencer
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state != S_IDLE)
    else $error("request accepted but sequencer idle");

endmodule
